[rtl/jvm_branch_target_unit_defines.svh]
// Assertion macros used by the top level of the branch target unit RTL.
`ifndef JVM_BRANCH_TARGET_UNIT_DEFINES_SVH
`define JVM_BRANCH_TARGET_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JBTU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JBTU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/jbtu_pkg.sv]
// Types and constants of the JVM branch target unit.
`timescale 1ns / 1ps
package jbtu_pkg;

	// Sequencer phases of one instruction.
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_PAD      = 4'd1,
		PH_T_DEF    = 4'd2,
		PH_T_LOW    = 4'd3,
		PH_T_HIGH   = 4'd4,
		PH_T_SKIP   = 4'd5,
		PH_T_ENTRY  = 4'd6,
		PH_L_DEF    = 4'd7,
		PH_L_NPAIRS = 4'd8,
		PH_L_MATCH  = 4'd9,
		PH_L_OFF    = 4'd10,
		PH_G_OFF    = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TABLE  = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_GOTO   = 2'd2,
		KIND_GOTOW  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PAIRS = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_BAD_OP    = 2'd3
	} status_t;

	localparam logic [7:0] OP_TABLE_SW  = 8'hAA;
	localparam logic [7:0] OP_LOOKUP_SW = 8'hAB;
	localparam logic [7:0] OP_GOTO      = 8'hA7;
	localparam logic [7:0] OP_GOTO_WIDE = 8'hC8;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// Opcode byte plus the two switch words (default and npairs).
	localparam int unsigned HDR_EXTRA = 9;

	typedef struct packed {
		logic               command;
		logic [7:0]         opcode;
		logic [15:0]        inst_pc;
		logic signed [31:0] switch_key;
		logic [16:0]        code_length;
		logic [7:0]         code_byte;
	} in_t;

	typedef struct packed {
		logic signed [31:0] next_pc;
		logic [1:0]         status;
	} out_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic valid;
		out_t item;
	} res_t;

endpackage

[rtl/jbtu_core.sv]
// Branch target sequencer: per-request state update and result generation.
`timescale 1ns / 1ps
module jbtu_core import jbtu_pkg::*; #(
	parameter int unsigned MAX_PAIRS = 65535
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  in_t  item,
	output res_t res
);

	localparam int unsigned PW = $clog2(MAX_PAIRS + 1);
	localparam int unsigned EW = ((PW + 3) > 18 ? (PW + 3) : 18) + 1;

	phase_t      phase_q, phase_d;
	kind_t       kind_q, kind_d;
	logic [15:0] base_pc_q, base_pc_d;
	logic [31:0] key_q, key_d;
	logic [16:0] limit_q, limit_d;
	logic [1:0]  pad_q, pad_d;
	logic [1:0]  biw_q, biw_d;
	logic [23:0] ws_q, ws_d;
	logic [31:0] def_q, def_d;
	logic [31:0] low_q, low_d;
	logic [PW-1:0] pairs_q, pairs_d;
	logic [31:0] skip_q, skip_d;
	logic        hit_q, hit_d;

	logic [31:0] word;
	logic [1:0]  need;
	logic        word_done;
	logic [31:0] goto_off;
	logic [31:0] base_ext;
	logic [17:0] begin_hdr_end;
	logic        begin_trunc;
	logic [1:0]  begin_pad;
	logic        out_of_range;
	logic [31:0] key_minus_low;
	logic        bad_pairs;
	logic [EW-1:0] table_end;
	logic        table_trunc;
	phase_t      first_phase;

	// The three bytes gathered so far followed by the incoming byte.
	assign word      = {ws_q, item.code_byte};
	assign need      = (phase_q == PH_G_OFF && kind_q == KIND_GOTO) ? 2'd1 : 2'd3;
	assign word_done = (biw_q == need);
	assign goto_off  = (kind_q == KIND_GOTO) ? {{16{word[15]}}, word[15:0]} : word;
	assign base_ext  = {16'd0, base_pc_q};

	// Padding brings the first operand word to a multiple of four.
	assign begin_pad     = ~item.inst_pc[1:0];
	assign begin_hdr_end = {2'b00, item.inst_pc | 16'h0003} + 18'(HDR_EXTRA);
	assign begin_trunc   = begin_hdr_end > {1'b0, item.code_length};

	assign out_of_range  = ($signed(key_q) < $signed(low_q)) || ($signed(key_q) > $signed(word));
	assign key_minus_low = key_q - low_q;

	assign bad_pairs   = word[31] || (word > 32'(MAX_PAIRS));
	assign table_end   = EW'({2'b00, base_pc_q | 16'h0003}) + EW'(HDR_EXTRA)
		+ EW'({word[PW-1:0], 3'b000});
	assign table_trunc = table_end > EW'(limit_q);

	assign first_phase = (kind_q == KIND_TABLE) ? PH_T_DEF : PH_L_DEF;

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		base_pc_d = base_pc_q;
		key_d     = key_q;
		limit_d   = limit_q;
		pad_d     = pad_q;
		biw_d     = biw_q;
		ws_d      = ws_q;
		def_d     = def_q;
		low_d     = low_q;
		pairs_d   = pairs_q;
		skip_d    = skip_q;
		hit_d     = hit_q;
		if (fire && item.command == CMD_BEGIN) begin
			base_pc_d = item.inst_pc;
			key_d     = item.switch_key;
			limit_d   = item.code_length;
			biw_d     = 2'd0;
			ws_d      = 24'd0;
			hit_d     = 1'b0;
			skip_d    = 32'd0;
			pairs_d   = '0;
			unique case (item.opcode)
				OP_TABLE_SW: begin
					kind_d  = KIND_TABLE;
					pad_d   = begin_pad;
					phase_d = (begin_pad != 2'd0) ? PH_PAD : PH_T_DEF;
				end
				OP_LOOKUP_SW: begin
					kind_d = KIND_LOOKUP;
					pad_d  = begin_pad;
					if (begin_trunc) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = (begin_pad != 2'd0) ? PH_PAD : PH_L_DEF;
					end
				end
				OP_GOTO: begin
					kind_d  = KIND_GOTO;
					phase_d = PH_G_OFF;
				end
				OP_GOTO_WIDE: begin
					kind_d  = KIND_GOTOW;
					phase_d = PH_G_OFF;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else if (fire && phase_q != PH_IDLE) begin
			if (phase_q == PH_PAD) begin
				pad_d = pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					phase_d = first_phase;
				end
			end else if (!word_done) begin
				biw_d = biw_q + 2'd1;
				ws_d  = word[23:0];
			end else begin
				biw_d = 2'd0;
				ws_d  = 24'd0;
				unique case (phase_q)
					PH_T_DEF: begin
						def_d   = word;
						phase_d = PH_T_LOW;
					end
					PH_T_LOW: begin
						low_d   = word;
						phase_d = PH_T_HIGH;
					end
					PH_T_HIGH: begin
						if (out_of_range) begin
							phase_d = PH_IDLE;
						end else begin
							skip_d  = key_minus_low;
							phase_d = (key_minus_low != 32'd0) ? PH_T_SKIP : PH_T_ENTRY;
						end
					end
					PH_T_SKIP: begin
						skip_d = skip_q - 32'd1;
						if (skip_q == 32'd1) begin
							phase_d = PH_T_ENTRY;
						end
					end
					PH_L_DEF: begin
						def_d   = word;
						phase_d = PH_L_NPAIRS;
					end
					PH_L_NPAIRS: begin
						if (bad_pairs || table_trunc || word == 32'd0) begin
							phase_d = PH_IDLE;
						end else begin
							pairs_d = word[PW-1:0];
							phase_d = PH_L_MATCH;
						end
					end
					PH_L_MATCH: begin
						hit_d   = (word == key_q);
						phase_d = PH_L_OFF;
					end
					PH_L_OFF: begin
						pairs_d = pairs_q - PW'(1);
						if (hit_q || pairs_q == PW'(1)) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_L_MATCH;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result generation.
	always_comb begin
		res.valid        = 1'b0;
		res.item.next_pc = 32'sd0;
		res.item.status  = ST_OK;
		if (fire && item.command == CMD_BEGIN) begin
			priority if (item.opcode != OP_TABLE_SW && item.opcode != OP_LOOKUP_SW
				&& item.opcode != OP_GOTO && item.opcode != OP_GOTO_WIDE) begin
				res.valid       = 1'b1;
				res.item.status = ST_BAD_OP;
			end else if (item.opcode == OP_LOOKUP_SW && begin_trunc) begin
				res.valid       = 1'b1;
				res.item.status = ST_TRUNCATED;
			end else begin
				res.valid = 1'b0;
			end
		end else if (fire && phase_q != PH_IDLE && phase_q != PH_PAD && word_done) begin
			unique case (phase_q)
				PH_G_OFF: begin
					res.valid        = 1'b1;
					res.item.next_pc = base_ext + goto_off;
				end
				PH_T_HIGH: begin
					if (out_of_range) begin
						res.valid        = 1'b1;
						res.item.next_pc = base_ext + def_q;
					end
				end
				PH_T_ENTRY: begin
					res.valid        = 1'b1;
					res.item.next_pc = base_ext + word;
				end
				PH_L_NPAIRS: begin
					priority if (bad_pairs) begin
						res.valid       = 1'b1;
						res.item.status = ST_BAD_PAIRS;
					end else if (table_trunc) begin
						res.valid       = 1'b1;
						res.item.status = ST_TRUNCATED;
					end else if (word == 32'd0) begin
						res.valid        = 1'b1;
						res.item.next_pc = base_ext + def_q;
					end else begin
						res.valid = 1'b0;
					end
				end
				PH_L_OFF: begin
					priority if (hit_q) begin
						res.valid        = 1'b1;
						res.item.next_pc = base_ext + word;
					end else if (pairs_q == PW'(1)) begin
						res.valid        = 1'b1;
						res.item.next_pc = base_ext + def_q;
					end else begin
						res.valid = 1'b0;
					end
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= KIND_TABLE;
			base_pc_q <= 16'd0;
			key_q     <= 32'd0;
			limit_q   <= 17'd0;
			pad_q     <= 2'd0;
			biw_q     <= 2'd0;
			ws_q      <= 24'd0;
			def_q     <= 32'd0;
			low_q     <= 32'd0;
			pairs_q   <= '0;
			skip_q    <= 32'd0;
			hit_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			base_pc_q <= base_pc_d;
			key_q     <= key_d;
			limit_q   <= limit_d;
			pad_q     <= pad_d;
			biw_q     <= biw_d;
			ws_q      <= ws_d;
			def_q     <= def_d;
			low_q     <= low_d;
			pairs_q   <= pairs_d;
			skip_q    <= skip_d;
			hit_q     <= hit_d;
		end
	end

endmodule

[rtl/jvm_branch_target_unit.sv]
// Top level of the JVM branch target unit.
`timescale 1ns / 1ps
// Works out the next pc of tableswitch, lookupswitch, goto and goto_w.
// Input channel (in_valid / in_ready / in_item): a begin request carries the
// opcode, instruction pc, switch key and code length; each following byte
// request carries one operand code byte, big-endian, padding included.
// Output channel (out_valid / out_ready / out_item): at most one result per
// request, either pc plus the selected offset wrapped to 32 bits with status
// zero, or an error status with next_pc zero. Bytes after a result, and bytes
// with no instruction in progress, are dropped; a begin abandons any
// instruction in progress.
// A request accepted into the input register is processed by the sequencer once
// the output register can take a result, and its result is registered there.
// Throughput: one request per cycle while the receiver keeps up. The input
// register holds one request and the output register one result; the
// result logic between them is combinational in the held request and state.
// When the receiver stalls with a result pending, the sequencer holds the
// request in the input register and in_ready drops once that register is full.
// Reset clears the sequencer to idle and empties both registers.
`include "jvm_branch_target_unit_defines.svh"
module jvm_branch_target_unit import jbtu_pkg::*; #(
	parameter int unsigned MAX_PAIRS = 65535
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	logic in_valid_s1;
	in_t  in_item_s1;
	logic out_valid_q;
	out_t out_item_q;
	logic step_fire;
	res_t res;

	// The sequencer advances only when the output register can take a result.
	assign step_fire = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || step_fire;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	jbtu_core #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (step_fire),
		.item   (in_item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				in_valid_s1 <= 1'b1;
			end else if (step_fire) begin
				in_valid_s1 <= 1'b0;
			end
			if (step_fire && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_item_s1 <= in_item;
		end
		if (step_fire && res.valid) begin
			out_item_q <= res.item;
		end
	end

	// A pending result that is not being taken must block the sequencer.
	`JBTU_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready, !step_fire, "result overwritten while stalled")
	// A held request stays in the input register until the sequencer takes it.
	`JBTU_ASSERT_NEXT(a_s1_held, clk, arst_n, in_valid_s1 && !step_fire, in_valid_s1, "input register lost a request")
	// A new result appears only from a sequencer step that produced one.
	`JBTU_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_valid_q), $past(step_fire && res.valid), "result without a producing step")

endmodule

[sim/tb_jvm_branch_target_unit.sv]
// Self-checking testbench for the JVM branch target unit: a directed pass and a random pass.
`timescale 1ns / 1ps
module tb_jvm_branch_target_unit import jbtu_pkg::*; ();

	// Pair count limit of the block under test; the predictor uses the same value.
	localparam int PAIR_LIMIT = 65535;

	// Tracks the instruction sequencer request by request. For every accepted
	// request it works out the branch target, if any, and keeps a queue of the
	// targets still owed by the block.
	class branch_target_scoreboard;
		phase_t      step;
		kind_t       kind;
		logic [15:0] pc_base;
		logic [31:0] key;
		logic [16:0] code_len;
		logic [1:0]  pad_left;
		logic [1:0]  byte_idx;
		logic [31:0] gather;
		logic [31:0] dflt;
		logic [31:0] lo;
		logic [15:0] pairs_left;
		logic [31:0] skip_left;
		logic        hit;
		out_t        targets[$];
		int          errors;
		int          results_seen;

		function new();
			step = PH_IDLE;
			kind = KIND_TABLE;
			pc_base = '0;
			key = '0;
			code_len = '0;
			pad_left = '0;
			byte_idx = '0;
			gather = '0;
			dflt = '0;
			lo = '0;
			pairs_left = '0;
			skip_left = '0;
			hit = 1'b0;
			errors = 0;
			results_seen = 0;
		endfunction

		// Switch operands start on the next 4-byte boundary after the opcode.
		function logic [1:0] align_pad(logic [15:0] pc);
			return 2'd3 - pc[1:0];
		endfunction

		function phase_t first_word();
			if (kind == KIND_TABLE)
				return PH_T_DEF;
			return PH_L_DEF;
		endfunction

		// Every result ends the instruction in progress.
		function void emit_target(logic [31:0] pc, status_t st);
			out_t e;
			e.next_pc = pc;
			e.status = st;
			targets.push_back(e);
			step = PH_IDLE;
		endfunction

		function void note_request(in_t r);
			logic [31:0] word;
			logic [1:0]  need;
			longint      table_end;
			if (r.command == CMD_BEGIN) begin
				pc_base = r.inst_pc;
				key = r.switch_key;
				code_len = r.code_length;
				byte_idx = '0;
				gather = '0;
				hit = 1'b0;
				skip_left = '0;
				pairs_left = '0;
				case (r.opcode)
					OP_TABLE_SW:  kind = KIND_TABLE;
					OP_LOOKUP_SW: kind = KIND_LOOKUP;
					OP_GOTO:      kind = KIND_GOTO;
					OP_GOTO_WIDE: kind = KIND_GOTOW;
					default: begin
						emit_target('0, ST_BAD_OP);
						return;
					end
				endcase
				if (kind == KIND_GOTO || kind == KIND_GOTOW) begin
					step = PH_G_OFF;
					return;
				end
				pad_left = align_pad(pc_base);
				// Only lookupswitch checks that its header fits in the code.
				if (kind == KIND_LOOKUP &&
						longint'(pc_base) + 9 + pad_left > longint'(code_len)) begin
					emit_target('0, ST_TRUNCATED);
					return;
				end
				if (pad_left != 0)
					step = PH_PAD;
				else
					step = first_word();
				return;
			end

			// A byte with nothing in progress is dropped.
			if (step == PH_IDLE)
				return;
			if (step == PH_PAD) begin
				pad_left = pad_left - 2'd1;
				if (pad_left == 0)
					step = first_word();
				return;
			end

			gather = {gather[23:0], r.code_byte};
			need = (step == PH_G_OFF && kind == KIND_GOTO) ? 2'd1 : 2'd3;
			if (byte_idx != need) begin
				byte_idx = byte_idx + 2'd1;
				return;
			end
			byte_idx = '0;
			word = gather;
			gather = '0;

			case (step)
				PH_G_OFF: begin
					if (kind == KIND_GOTO)
						word = {{16{word[15]}}, word[15:0]};
					emit_target({16'h0, pc_base} + word, ST_OK);
				end
				PH_T_DEF: begin
					dflt = word;
					step = PH_T_LOW;
				end
				PH_T_LOW: begin
					lo = word;
					step = PH_T_HIGH;
				end
				PH_T_HIGH: begin
					if ($signed(key) < $signed(lo) || $signed(key) > $signed(word)) begin
						emit_target({16'h0, pc_base} + dflt, ST_OK);
					end else begin
						skip_left = key - lo;
						if (skip_left != 0)
							step = PH_T_SKIP;
						else
							step = PH_T_ENTRY;
					end
				end
				PH_T_SKIP: begin
					skip_left = skip_left - 32'd1;
					if (skip_left == 0)
						step = PH_T_ENTRY;
				end
				PH_T_ENTRY: emit_target({16'h0, pc_base} + word, ST_OK);
				PH_L_DEF: begin
					dflt = word;
					step = PH_L_NPAIRS;
				end
				PH_L_NPAIRS: begin
					if (word[31] || word > PAIR_LIMIT) begin
						emit_target('0, ST_BAD_PAIRS);
					end else begin
						table_end = longint'(pc_base) + 9 + align_pad(pc_base) +
							longint'(word) * 8;
						if (table_end > longint'(code_len))
							emit_target('0, ST_TRUNCATED);
						else if (word == 0)
							emit_target({16'h0, pc_base} + dflt, ST_OK);
						else begin
							pairs_left = word[15:0];
							step = PH_L_MATCH;
						end
					end
				end
				PH_L_MATCH: begin
					hit = (word == key);
					step = PH_L_OFF;
				end
				PH_L_OFF: begin
					if (hit) begin
						emit_target({16'h0, pc_base} + word, ST_OK);
					end else begin
						pairs_left = pairs_left - 16'd1;
						if (pairs_left == 0)
							emit_target({16'h0, pc_base} + dflt, ST_OK);
						else
							step = PH_L_MATCH;
					end
				end
				default: step = PH_IDLE;
			endcase
		endfunction

		function void check_result(out_t got);
			out_t want;
			results_seen++;
			if (targets.size() == 0) begin
				$display("%0t: result with none expected: next_pc %h status %0d",
					$time, got.next_pc, got.status);
				errors++;
				return;
			end
			want = targets.pop_front();
			if (got.next_pc !== want.next_pc) begin
				$display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_item;

	// While set, neither side inserts idle cycles.
	logic calm = 1'b0;

	branch_target_scoreboard sb;
	int requests_sent = 0;
	int table_runs = 0;
	int lookup_runs = 0;
	int jump_runs = 0;
	int noise_runs = 0;

	jvm_branch_target_unit #(.MAX_PAIRS(PAIR_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random outside the calm stretch.
	always @(posedge clk) begin
		out_ready <= arst_n && (calm || $urandom_range(0, 99) >= 16);
	end

	// All inputs change at rising edges only, so the values seen at the falling
	// edge are the ones the next rising edge samples.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	// Called right after a rising edge; returns right after the edge that
	// accepted the request. Valid is only lowered when an idle gap follows.
	task automatic send_request(input in_t r);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 16)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= r;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
		end while (!in_ready);
		sb.note_request(r);
		requests_sent++;
		@(posedge clk);
	endtask

	task automatic push_begin(input logic [7:0] op, input logic [15:0] pc,
			input logic [31:0] key, input logic [16:0] len);
		in_t r;
		r.command = CMD_BEGIN;
		r.opcode = op;
		r.inst_pc = pc;
		r.switch_key = key;
		r.code_length = len;
		r.code_byte = 8'($urandom);
		send_request(r);
	endtask

	// Fields other than the byte are ignored by the block and carry noise.
	task automatic push_byte(input logic [7:0] b);
		in_t r;
		r.command = CMD_BYTE;
		r.opcode = 8'($urandom);
		r.inst_pc = 16'($urandom);
		r.switch_key = $urandom;
		r.code_length = 17'($urandom_range(0, 65536));
		r.code_byte = b;
		send_request(r);
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			push_byte(w[8*i +: 8]);
	endtask

	task automatic push_pad(input logic [15:0] pc);
		int pad;
		pad = 3 - pc[1:0];
		repeat (pad) push_byte(8'($urandom));
	endtask

	// Mostly small in-range tables; bounds near the ends of the integer range,
	// inverted bounds and keys just outside the table now and then.
	task automatic run_tableswitch();
		logic [15:0] pc;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] key;
		int          span;
		int          mode;
		pc = 16'($urandom);
		span = $urandom_range(0, 5);
		mode = $urandom_range(0, 9);
		case (mode)
			0: lo = 32'h8000_0000 + $urandom_range(0, 2);
			1: lo = 32'h7FFF_FFFF - $urandom_range(0, 6);
			2: lo = $urandom_range(0, 10) - 5;
			default: lo = $urandom;
		endcase
		hi = lo + span;
		if (mode == 3)
			hi = lo - $urandom_range(1, 4);
		case ($urandom_range(0, 9))
			0: key = lo - $urandom_range(1, 3);
			1: key = hi + $urandom_range(1, 3);
			2: key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: key = lo + $urandom_range(0, span);
		endcase
		push_begin(OP_TABLE_SW, pc, key, 17'($urandom_range(0, 65536)));
		push_pad(pc);
		push_word($urandom);
		push_word(lo);
		push_word(hi);
		// When the key is in range the whole jump table goes out; entries after the chosen one are dropped.
		if ($signed(key) >= $signed(lo) && $signed(key) <= $signed(hi))
			repeat (hi - lo + 1) push_word($urandom);
		table_runs++;
	endtask

	// Mostly well-formed pair tables of up to five pairs; bad pair counts and
	// code lengths that cut off the header or the pair table now and then.
	task automatic run_lookupswitch();
		logic [15:0] pc;
		logic [31:0] key;
		logic [31:0] npairs;
		longint      hdr_end;
		longint      tbl_end;
		longint      len;
		int          n;
		int          pick;
		pc = 16'($urandom);
		if ($urandom_range(0, 7) == 0)
			key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			key = $urandom;
		n = $urandom_range(0, 5);
		npairs = n;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			npairs = 32'h8000_0000 | $urandom;
		else if (pick == 1)
			npairs = 32'd65536 + $urandom_range(0, 3);
		else if (pick == 2)
			npairs = 32'h7FFF_FFFF;
		else if (pick == 3)
			npairs = PAIR_LIMIT;
		hdr_end = longint'(pc) + 9 + (3 - pc[1:0]);
		tbl_end = hdr_end + 8 * n;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = hdr_end - 1;
		else if (pick == 1)
			len = tbl_end - 1;
		else
			len = tbl_end + $urandom_range(0, 40);
		if (len > 65536)
			len = 65536;
		push_begin(OP_LOOKUP_SW, pc, key, 17'(len));
		lookup_runs++;
		if (hdr_end > len)
			return;
		push_pad(pc);
		push_word($urandom);
		push_word(npairs);
		if (npairs == n && tbl_end <= len) begin
			for (int i = 0; i < n; i++) begin
				push_word(($urandom_range(0, 3) == 0) ? key : $urandom);
				push_word($urandom);
			end
		end
	endtask

	task automatic run_jump(input logic wide);
		push_begin(wide ? OP_GOTO_WIDE : OP_GOTO, 16'($urandom), $urandom,
			17'($urandom_range(0, 65536)));
		repeat (wide ? 4 : 2) push_byte(8'($urandom));
		// A byte after the result is dropped.
		if ($urandom_range(0, 4) == 0)
			push_byte(8'($urandom));
		jump_runs++;
	endtask

	// Unsupported opcodes, bytes with nothing in progress, and switches that
	// a following begin cuts short.
	task automatic run_noise();
		logic [7:0] op;
		int         choice;
		choice = $urandom_range(0, 2);
		if (choice == 0) begin
			do begin
				op = 8'($urandom);
			end while (op == OP_TABLE_SW || op == OP_LOOKUP_SW ||
				op == OP_GOTO || op == OP_GOTO_WIDE);
			push_begin(op, 16'($urandom), $urandom, 17'($urandom_range(0, 65536)));
		end else if (choice == 1) begin
			push_byte(8'($urandom));
		end else begin
			push_begin($urandom_range(0, 1) ? OP_TABLE_SW : OP_LOOKUP_SW,
				16'($urandom), $urandom, 17'd65536);
			repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
		end
		noise_runs++;
	endtask

	initial begin
		int random_start;
		int choice;
		int drained;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// A byte with no instruction in progress.
		push_byte(8'hFF);
		// Unsupported opcodes at both ends of the opcode range.
		push_begin('0, 16'hFFFF, 32'h8000_0000, 17'd0);
		push_begin('1, 16'h0000, 32'h7FFF_FFFF, 17'd65536);
		// goto with the largest forward and backward offsets.
		push_begin(OP_GOTO, 16'hFFFF, '0, '0);
		push_byte(8'h7F);
		push_byte(8'hFF);
		push_begin(OP_GOTO, 16'h0000, '1, 17'd65536);
		push_byte(8'h80);
		push_byte(8'h00);
		// goto_w whose target overflows the signed 32-bit range.
		push_begin(OP_GOTO_WIDE, 16'hFFFF, '0, '0);
		push_word(32'h7FFF_FFFF);
		// lookupswitch whose header does not fit in an empty method.
		push_begin(OP_LOOKUP_SW, 16'h0000, $urandom, 17'd0);
		// lookupswitch with no padding and a negative pair count.
		push_begin(OP_LOOKUP_SW, 16'h0003, $urandom, 17'd65536);
		push_word(32'h0000_0000);
		push_word(32'hFFFF_FFFF);

		// Random part, with a stretch in the middle where nobody idles.
		random_start = requests_sent;
		while (requests_sent - random_start < 700) begin
			calm = (requests_sent - random_start >= 250) &&
				(requests_sent - random_start < 400);
			choice = $urandom_range(0, 99);
			if (choice < 32)
				run_tableswitch();
			else if (choice < 64)
				run_lookupswitch();
			else if (choice < 76)
				run_jump(1'b0);
			else if (choice < 88)
				run_jump(1'b1);
			else
				run_noise();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		drained = 0;
		while (sb.targets.size() != 0 && drained < 10000) begin
			@(posedge clk);
			drained++;
		end
		// Wait on so that a spurious late result would still be seen.
		repeat (8) @(posedge clk);
		if (sb.targets.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.targets.size());
			sb.errors += sb.targets.size();
		end

		$display("Sent %0d requests: %0d tableswitch, %0d lookupswitch, %0d goto or goto_w,",
			requests_sent, table_runs, lookup_runs, jump_runs);
		$display("%0d broken or stray sequences; %0d results compared.",
			noise_runs, sb.results_seen);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[jvm_branch_target_unit.f]
+incdir+rtl
rtl/jbtu_pkg.sv
rtl/jbtu_core.sv
rtl/jvm_branch_target_unit.sv
sim/tb_jvm_branch_target_unit.sv
